>>> src/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers. They compile away when SYNTHESIS is set.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Checks an implication at every rising clock edge outside reset.
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication assertion failed");

// Checks that a condition holds at every rising clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("invariant assertion failed");

// Checks that a condition at one edge is followed by another at the next edge.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle assertion failed");

`else

`define ASSERT_IMPLY(label, clk, rst, ante, cons)
`define ASSERT_ALWAYS(label, clk, rst, cond)
`define ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

>>> src/swa_pkg.sv
// ---------------------------------------------------------------------------
// swa_pkg
// Types and constants shared by the stopwatch and alarm controller modules.
// ---------------------------------------------------------------------------
package swa_pkg;

   localparam logic [31:0] ALERT_RESET = 32'd80;
   localparam logic [31:0] ALERT_STEP  = 32'd5;
   localparam logic [5:0]  MINUTE_LAST = 6'd59;
   localparam logic [31:0] AWARD_GAP   = 32'd10;
   localparam logic [1:0]  SONG_RESET  = 2'd2;

   // Item kinds.
   localparam logic [1:0] MODE_TICK  = 2'd0;
   localparam logic [1:0] MODE_SHORT = 2'd1;
   localparam logic [1:0] MODE_LONG  = 2'd2;

   // Keys.
   localparam logic [2:0] KEY_UP    = 3'd0;
   localparam logic [2:0] KEY_DOWN  = 3'd1;
   localparam logic [2:0] KEY_RIGHT = 3'd2;
   localparam logic [2:0] KEY_LEFT  = 3'd3;
   localparam logic [2:0] KEY_OK    = 3'd4;
   localparam logic [2:0] KEY_BACK  = 3'd5;

   // Song choices.
   localparam logic [1:0] SONG_OFF    = 2'd0;
   localparam logic [1:0] SONG_ONE    = 2'd1;
   localparam logic [1:0] SONG_TWO    = 2'd2;
   localparam logic [1:0] SONG_MINUTE = 2'd3;

   // Alert codes.
   localparam logic [2:0] ALERT_NONE     = 3'd0;
   localparam logic [2:0] ALERT_ONE_BASE = 3'd1;
   localparam logic [2:0] ALERT_TWO_BASE = 3'd4;
   localparam logic [2:0] ALERT_SILENT   = 3'd7;

   typedef struct packed {
      logic [1:0]  mode;
      logic [2:0]  key;
      logic [31:0] now_seconds;
   } req_item_type;

   typedef struct packed {
      logic        start_stop_chirp;
      logic        minute_chime;
      logic [2:0]  alert_code;
      logic        award;
      logic        award_random;
      logic        exit_request;
      logic [31:0] elapsed_seconds;
      logic        stopwatch_active;
      logic        running;
      logic [1:0]  song_choice;
      logic [31:0] alert_second;
      logic        hour_24;
   } rsp_item_type;

endpackage

>>> src/swa_input_reg.sv
// ---------------------------------------------------------------------------
// swa_input_reg
// Input register stage that captures one request word and holds it until used.
// ---------------------------------------------------------------------------
module swa_input_reg
   import swa_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         in_valid,
   output logic         in_ready,
   input  req_item_type in_item,
   output logic         out_valid,
   input  logic         out_take,
   output req_item_type out_item
);

   logic         valid_ff, valid_in;
   req_item_type item_ff;

   assign in_ready  = !valid_ff || out_take;
   assign valid_in  = in_ready ? in_valid : valid_ff;
   assign out_valid = valid_ff;
   assign out_item  = item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (in_ready && in_valid) begin
         item_ff <= in_item;
      end
   end

endmodule

>>> src/swa_event_unit.sv
// ---------------------------------------------------------------------------
// swa_event_unit
// Stopwatch and alarm state with the single-pass update for one event.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module swa_event_unit
   import swa_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         dumb_mode,
   input  logic         fire,
   input  req_item_type item,
   output rsp_item_type result
);

   logic        run_ff, run_in;
   logic [31:0] start_ff, start_in;
   logic [31:0] paused_ff, paused_in;
   logic [31:0] tick_ff, tick_in;
   logic [5:0]  phase_ff, phase_in;   // tick count modulo 60, kept alongside
   logic [31:0] alert_ff, alert_in;
   logic [1:0]  song_ff, song_in;
   logic        h24_ff, h24_in;
   logic [31:0] award_time_ff, award_time_in;

   always_comb begin
      logic [31:0] now;
      logic        award_ok;
      logic [2:0]  base;
      now      = item.now_seconds;
      award_ok = (award_time_ff + AWARD_GAP) <= now;
      base     = (song_ff == SONG_ONE) ? ALERT_ONE_BASE : ALERT_TWO_BASE;

      run_in        = run_ff;
      start_in      = start_ff;
      paused_in     = paused_ff;
      tick_in       = tick_ff;
      phase_in      = phase_ff;
      alert_in      = alert_ff;
      song_in       = song_ff;
      h24_in        = h24_ff;
      award_time_in = award_time_ff;
      result        = '0;

      unique case (item.mode)
         MODE_TICK: begin
            if (run_ff) begin
               tick_in = tick_ff + 32'd1;
               // A 32-bit wrap lands on zero, which is a multiple of 60 again.
               if (tick_ff == 32'hFFFF_FFFF || phase_ff == MINUTE_LAST) begin
                  phase_in = 6'd0;
               end else begin
                  phase_in = phase_ff + 6'd1;
               end
               result.minute_chime = (phase_in == 6'd0) && (tick_in != 32'd0);
               if (song_ff == SONG_ONE || song_ff == SONG_TWO) begin
                  priority if (tick_in == alert_ff) begin
                     result.alert_code = base;
                     result.award      = award_ok;
                     if (award_ok) begin
                        award_time_in = now;
                     end
                  end else if (tick_in == alert_ff + 32'd1) begin
                     result.alert_code = base + 3'd1;
                  end else if (tick_in == alert_ff + 32'd2) begin
                     result.alert_code = base + 3'd2;
                  end else begin
                  end
               end else if (tick_in == alert_ff) begin
                  result.alert_code   = ALERT_SILENT;
                  result.award        = award_ok;
                  result.award_random = award_ok;
                  if (award_ok) begin
                     award_time_in = now;
                  end
               end
            end
         end
         MODE_SHORT: begin
            unique case (item.key)
               KEY_UP: begin
                  if (run_ff) begin
                     alert_in = alert_ff + ALERT_STEP;
                  end
               end
               KEY_DOWN: begin
                  if (run_ff) begin
                     alert_in = alert_ff - ALERT_STEP;
                  end
               end
               KEY_RIGHT: begin
                  song_in = song_ff + 2'd1;
               end
               KEY_LEFT: begin
                  if (start_ff != 32'd0) begin
                     start_in  = now;
                     paused_in = 32'd0;
                     tick_in   = 32'd0;
                     phase_in  = 6'd0;
                  end else if (!dumb_mode) begin
                     h24_in = !h24_ff;
                  end
               end
               KEY_OK: begin
                  if (!dumb_mode) begin
                     result.start_stop_chirp = (song_ff != SONG_OFF);
                     priority if (run_ff) begin
                        paused_in = now - start_ff;
                     end else if (start_ff == 32'd0) begin
                        start_in = now;
                     end else begin
                        start_in = now - paused_ff;
                     end
                     run_in = !run_ff;
                  end
               end
               KEY_BACK: begin
                  result.exit_request = 1'b1;
               end
               default: begin
               end
            endcase
         end
         MODE_LONG: begin
            if (item.key == KEY_LEFT && start_ff != 32'd0) begin
               run_in    = 1'b0;
               start_in  = 32'd0;
               paused_in = 32'd0;
               tick_in   = 32'd0;
               phase_in  = 6'd0;
            end
         end
         default: begin
         end
      endcase

      result.elapsed_seconds  = run_in ? (now - start_in) : paused_in;
      result.stopwatch_active = (start_in != 32'd0);
      result.running          = run_in;
      result.song_choice      = song_in;
      result.alert_second     = alert_in;
      result.hour_24          = h24_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff        <= 1'b0;
         start_ff      <= 32'd0;
         paused_ff     <= 32'd0;
         tick_ff       <= 32'd0;
         phase_ff      <= 6'd0;
         alert_ff      <= ALERT_RESET;
         song_ff       <= SONG_RESET;
         h24_ff        <= 1'b0;
         award_time_ff <= 32'd0;
      end else if (fire) begin
         run_ff        <= run_in;
         start_ff      <= start_in;
         paused_ff     <= paused_in;
         tick_ff       <= tick_in;
         phase_ff      <= phase_in;
         alert_ff      <= alert_in;
         song_ff       <= song_in;
         h24_ff        <= h24_in;
         award_time_ff <= award_time_in;
      end
   end

   `ASSERT_ALWAYS(a_phase_range, clock, reset, phase_ff <= MINUTE_LAST)
   `ASSERT_IMPLY(a_award_stage, clock, reset, fire && result.award, result.alert_code == ALERT_ONE_BASE || result.alert_code == ALERT_TWO_BASE || result.alert_code == ALERT_SILENT)
   `ASSERT_IMPLY(a_random_award, clock, reset, fire && result.award_random, result.award && result.alert_code == ALERT_SILENT)
   `ASSERT_NEXT(a_tick_advance, clock, reset, fire && item.mode == MODE_TICK && run_ff, tick_ff == $past(tick_ff) + 32'd1)

endmodule

>>> src/swa_result_reg.sv
// ---------------------------------------------------------------------------
// swa_result_reg
// Result register that holds one response word until the consumer takes it.
// ---------------------------------------------------------------------------
module swa_result_reg
   import swa_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         in_valid,
   output logic         in_ready,
   input  rsp_item_type in_item,
   output logic         out_valid,
   input  logic         out_ready,
   output rsp_item_type out_item
);

   logic         valid_ff, valid_in;
   rsp_item_type item_ff;

   assign in_ready  = !valid_ff || out_ready;
   assign valid_in  = in_ready ? in_valid : valid_ff;
   assign out_valid = valid_ff;
   assign out_item  = item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (in_ready && in_valid) begin
         item_ff <= in_item;
      end
   end

endmodule

>>> src/stopwatch_alarm_controller.sv
// ---------------------------------------------------------------------------
// stopwatch_alarm_controller
// Stopwatch with alarm: key events and one-second ticks in, one status word out.
// ---------------------------------------------------------------------------
// Every request word (a tick or a key event, each with the current clock
// seconds) produces exactly one response word that carries the event flags and
// the stopwatch status after the event. The block sustains one word per clock
// cycle: a word lands in the input register, the whole state update is one
// combinational pass in the event unit, and the response lands in the result
// register, which drives rsp_tvalid. Back-pressure on the response side holds
// the result register, then the input register, and only then drops
// req_tready. The dumb_mode register is written through the csr port, which
// is always ready; write it only while no words are in flight.
module stopwatch_alarm_controller
   import swa_pkg::*;
(
   input  logic        clock,
   input  logic        reset,

   // Request channel.
   input  logic        req_tvalid,
   output logic        req_tready,
   // key [2:0], now_seconds [34:3], zero fill [39:35]
   input  logic [39:0] req_tdata,
   // mode [1:0]
   input  logic [1:0]  req_tuser,

   // Response channel.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // start_stop_chirp [0], minute_chime [1], alert_code [4:2], award [5],
   // award_random [6], exit_request [7], elapsed_seconds [39:8],
   // stopwatch_active [40], running [41], song_choice [43:42],
   // alert_second [75:44], hour_24 [76], zero fill [79:77]
   output logic [79:0] rsp_tdata,

   // Configuration write channel: dumb_mode.
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_data
);

   req_item_type req_item, staged_item;
   rsp_item_type unit_result, rsp_item;
   logic         staged_valid;
   logic         result_ready;
   logic         fire;
   logic         dumb_mode_ff, dumb_mode_in;

   // Unpack the request word.
   assign req_item.mode        = req_tuser;
   assign req_item.key         = req_tdata[2:0];
   assign req_item.now_seconds = req_tdata[34:3];

   // The configuration register takes a write in any cycle.
   assign csr_ready    = 1'b1;
   assign dumb_mode_in = (csr_valid && csr_ready) ? csr_data : dumb_mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         dumb_mode_ff <= 1'b0;
      end else begin
         dumb_mode_ff <= dumb_mode_in;
      end
   end

   // An event is applied when a staged word meets a free result slot.
   assign fire = staged_valid && result_ready;

   swa_input_reg u_input_reg (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_item   (req_item),
      .out_valid (staged_valid),
      .out_take  (result_ready),
      .out_item  (staged_item)
   );

   swa_event_unit u_event_unit (
      .clock     (clock),
      .reset     (reset),
      .dumb_mode (dumb_mode_ff),
      .fire      (fire),
      .item      (staged_item),
      .result    (unit_result)
   );

   swa_result_reg u_result_reg (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (staged_valid),
      .in_ready  (result_ready),
      .in_item   (unit_result),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_item  (rsp_item)
   );

   // Pack the response word, first field in the lowest bits.
   assign rsp_tdata = {3'b000,
                       rsp_item.hour_24,
                       rsp_item.alert_second,
                       rsp_item.song_choice,
                       rsp_item.running,
                       rsp_item.stopwatch_active,
                       rsp_item.elapsed_seconds,
                       rsp_item.exit_request,
                       rsp_item.award_random,
                       rsp_item.award,
                       rsp_item.alert_code,
                       rsp_item.minute_chime,
                       rsp_item.start_stop_chirp};

endmodule
